/* hw/rtl/trl_pkg.sv */
// ----------------------------------------------------------------------------
// trl_pkg: shared types and constants of the traffic light controller
// Payload structs, phase/command/mode codes, lamp and segment patterns.
// ----------------------------------------------------------------------------
package trl_pkg;

    localparam int CNT_W    = 7;
    localparam int CFG_IDX_W = 2;

    // phase codes
    localparam logic [1:0] PH_RED    = 2'd0;
    localparam logic [1:0] PH_YELLOW = 2'd1;
    localparam logic [1:0] PH_GREEN  = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    // command codes
    localparam logic [1:0] CMD_STEP   = 2'd0;
    localparam logic [1:0] CMD_SCAN   = 2'd1;
    localparam logic [1:0] CMD_RELOAD = 2'd2;

    // operating modes
    localparam logic [2:0] MODE_NORMAL = 3'd1;
    localparam logic [2:0] MODE_RED    = 3'd2;
    localparam logic [2:0] MODE_YELLOW = 3'd3;
    localparam logic [2:0] MODE_GREEN  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_TIME  = 2'd2;

    // timer reloads
    localparam logic [7:0] TICKS_NONE   = 8'd0;
    localparam logic [7:0] TICKS_NORMAL = 8'd250;
    localparam logic [7:0] TICKS_BLINK  = 8'd200;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [2:0] SCAN_LAST = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] op_mode;
        logic [6:0] shown_draft;
    } t_in_item;

    typedef struct packed {
        logic [5:0] lamps;
        logic [6:0] segments;
        logic [4:0] digit_enables;
        logic [7:0] reload_ticks;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] red;
        logic [CNT_W-1:0] yellow;
        logic [CNT_W-1:0] green;
    } t_times;

    // active-low lamps of one road: bit 0 red, bit 1 yellow, bit 2 green
    function automatic logic [2:0] f_phase_lamps(input logic [1:0] ph);
        logic [2:0] lamps;
        case (ph)
            PH_YELLOW: lamps = 3'b101;
            PH_GREEN:  lamps = 3'b011;
            default:   lamps = 3'b110;
        endcase
        return lamps;
    endfunction

    // active-low segments a..g from bit 0
    function automatic logic [6:0] f_seg(input logic [3:0] d);
        logic [6:0] seg;
        case (d)
            4'd0:    seg = 7'h40;
            4'd1:    seg = 7'h79;
            4'd2:    seg = 7'h24;
            4'd3:    seg = 7'h30;
            4'd4:    seg = 7'h19;
            4'd5:    seg = 7'h12;
            4'd6:    seg = 7'h02;
            4'd7:    seg = 7'h78;
            4'd8:    seg = 7'h00;
            4'd9:    seg = 7'h10;
            default: seg = 7'h7F;
        endcase
        return seg;
    endfunction

endpackage

/* hw/rtl/trl_road.sv */
// ----------------------------------------------------------------------------
// trl_road: next phase and count of one road on a normal-mode step
// Counts down; on underflow moves red -> green -> yellow -> red.
// ----------------------------------------------------------------------------
module trl_road
    import trl_pkg::*;
(
    input  logic [1:0]       i_phase,
    input  logic [CNT_W-1:0] i_count,
    input  t_times           i_times,
    output logic [1:0]       o_phase,
    output logic [CNT_W-1:0] o_count
);

    logic [CNT_W-1:0] w_time;

    always_comb begin
        case (i_phase)
            PH_YELLOW: begin
                o_phase = PH_RED;
                w_time  = i_times.red;
            end
            PH_GREEN: begin
                o_phase = PH_YELLOW;
                w_time  = i_times.yellow;
            end
            default: begin
                // red, and the unused code
                o_phase = PH_GREEN;
                w_time  = i_times.green;
            end
        endcase

        if (i_count != '0) begin
            o_phase = i_phase;
            o_count = i_count - CNT_W'(1);
        end else if (w_time == '0) begin
            o_count = '0;
        end else begin
            o_count = w_time - CNT_W'(1);
        end
    end

endmodule

/* hw/rtl/two_road_traffic_light_with_scan_display_core.sv */
// ----------------------------------------------------------------------------
// two_road_traffic_light_with_scan_display_core: two-road light controller
// Phase counters, blink edit modes and a five-digit multiplexed display.
// ----------------------------------------------------------------------------
// Each accepted item (timer step, scan, reload) produces exactly one result
// carrying the current lamp, segment and digit-enable levels plus the timer
// reload. Throughput is one item per clock unless the output stalls. The
// item is captured in an input register, then the whole state update (both
// road counters, lamp toggling, digit split and segment decode) runs in one
// pass into the state and result registers. The result register is the only
// output buffer, so the input side stalls only while a finished result is
// held by downstream stall and another item already sits in the input
// register. Configuration writes are always ready and take effect on the
// next reload or phase underflow; write them only while the block is idle.
module two_road_traffic_light_with_scan_display_core
    import trl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    // ---- handshake -------------------------------------------------------
    logic     r_in_vld;
    t_in_item r_in;
    logic     r_out_vld;
    logic     w_out_free;  // result register can take a new result
    logic     w_fire;      // input register moves into the result register

    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_fire      = r_in_vld && w_out_free;
    assign o_in_stall  = r_in_vld && !w_out_free;
    assign o_out_valid = r_out_vld;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    // ---- configuration ---------------------------------------------------
    t_times r_times;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_times.red    <= CNT_W'(5);
            r_times.yellow <= CNT_W'(2);
            r_times.green  <= CNT_W'(3);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RED_TIME:    r_times.red    <= i_cfg_data;
                REG_YELLOW_TIME: r_times.yellow <= i_cfg_data;
                REG_GREEN_TIME:  r_times.green  <= i_cfg_data;
                default: ;       // index beyond the register list
            endcase
        end
    end

    // ---- state -----------------------------------------------------------
    logic [1:0]       r_ph1, r_ph2, n_ph1, n_ph2;
    logic [CNT_W-1:0] r_cnt1, r_cnt2, n_cnt1, n_cnt2;
    logic [5:0]       r_lamps, n_lamps;
    logic [6:0]       r_seg, n_seg;
    logic [4:0]       r_en, n_en;
    logic [2:0]       r_scan, n_scan;
    logic [7:0]       n_ticks;
    t_out_item        r_out;

    // road updates used on a normal-mode step
    logic [1:0]       w_ph1, w_ph2;
    logic [CNT_W-1:0] w_cnt1, w_cnt2;

    trl_road u_road1 (
        .i_phase (r_ph1),
        .i_count (r_cnt1),
        .i_times (r_times),
        .o_phase (w_ph1),
        .o_count (w_cnt1)
    );

    trl_road u_road2 (
        .i_phase (r_ph2),
        .i_count (r_cnt2),
        .i_times (r_times),
        .o_phase (w_ph2),
        .o_count (w_cnt2)
    );

    // ---- scan digit split ------------------------------------------------
    logic [2:0]       w_pos;
    logic [CNT_W-1:0] w_v1, w_v2, w_sel;
    logic [14:0]      w_prod;
    logic [3:0]       w_tens, w_units, w_digit;
    logic [CNT_W-1:0] w_rem;

    assign w_pos = (r_scan > SCAN_LAST) ? 3'd0 : r_scan;

    always_comb begin
        case (r_in.op_mode)
            MODE_NORMAL: begin
                w_v1 = r_cnt1;
                w_v2 = r_cnt2;
            end
            MODE_RED, MODE_YELLOW, MODE_GREEN: begin
                w_v1 = r_in.shown_draft;
                w_v2 = r_in.shown_draft;
            end
            default: begin
                w_v1 = '0;
                w_v2 = '0;
            end
        endcase
    end

    // positions 0 and 1 show road 1, 2 and 3 show road 2
    assign w_sel = (w_pos < 3'd2) ? w_v1 : w_v2;

    // divide by ten: 205/2048 is exact for 7-bit values
    assign w_prod  = 15'(w_sel) * 15'd205;
    assign w_tens  = w_prod[14:11];
    assign w_rem   = w_sel - CNT_W'({w_tens, 3'b000}) - CNT_W'({w_tens, 1'b0});
    assign w_units = w_rem[3:0];

    always_comb begin
        case (w_pos)
            3'd0, 3'd2: w_digit = w_tens;
            3'd1, 3'd3: w_digit = w_units;
            default:    w_digit = {1'b0, r_in.op_mode};
        endcase
    end

    // ---- next state ------------------------------------------------------
    always_comb begin
        n_ph1   = r_ph1;
        n_ph2   = r_ph2;
        n_cnt1  = r_cnt1;
        n_cnt2  = r_cnt2;
        n_lamps = r_lamps;
        n_seg   = r_seg;
        n_en    = r_en;
        n_scan  = r_scan;
        n_ticks = TICKS_NONE;

        case (r_in.command)
            CMD_STEP: begin
                case (r_in.op_mode)
                    MODE_NORMAL: begin
                        n_ph1   = w_ph1;
                        n_ph2   = w_ph2;
                        n_cnt1  = w_cnt1;
                        n_cnt2  = w_cnt2;
                        n_lamps = {f_phase_lamps(w_ph2), f_phase_lamps(w_ph1)};
                        n_ticks = TICKS_NORMAL;
                    end
                    // edit modes: blink that color on both roads, rest off
                    MODE_RED: begin
                        n_lamps = (~r_lamps & 6'b001001) | 6'b110110;
                        n_ticks = TICKS_BLINK;
                    end
                    MODE_YELLOW: begin
                        n_lamps = (~r_lamps & 6'b010010) | 6'b101101;
                        n_ticks = TICKS_BLINK;
                    end
                    MODE_GREEN: begin
                        n_lamps = (~r_lamps & 6'b100100) | 6'b011011;
                        n_ticks = TICKS_BLINK;
                    end
                    default: ;  // idle mode
                endcase
            end
            CMD_SCAN: begin
                n_en   = 5'(1) << w_pos;
                n_scan = (w_pos == SCAN_LAST) ? 3'd0 : 3'(w_pos + 3'd1);
                // values above nine leave the segments as they were
                if (w_digit <= DIGIT_MAX) begin
                    n_seg = f_seg(w_digit);
                end
            end
            CMD_RELOAD: begin
                n_cnt1 = r_times.red;
                n_cnt2 = r_times.green;
                n_ph1  = PH_RED;
                n_ph2  = PH_GREEN;
            end
            default: ;  // unused command
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1   <= PH_RED;
            r_ph2   <= PH_GREEN;
            r_cnt1  <= CNT_W'(5);
            r_cnt2  <= CNT_W'(3);
            r_lamps <= '1;
            r_seg   <= '1;
            r_en    <= '0;
            r_scan  <= '0;
        end else if (w_fire) begin
            r_ph1   <= n_ph1;
            r_ph2   <= n_ph2;
            r_cnt1  <= n_cnt1;
            r_cnt2  <= n_cnt2;
            r_lamps <= n_lamps;
            r_seg   <= n_seg;
            r_en    <= n_en;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.lamps         <= n_lamps;
            r_out.segments      <= n_seg;
            r_out.digit_enables <= n_en;
            r_out.reload_ticks  <= n_ticks;
        end
    end

    assign o_out = r_out;

    // ---- assertions ------------------------------------------------------
`ifndef ASSERT_OFF
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_LAST)
        else $error("scan position out of range");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph1 != PH_UNUSED && r_ph2 != PH_UNUSED)
        else $error("unused phase code reached");

    a_enables_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_en))
        else $error("digit enables not one-hot");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_vld))
        else $error("result without a captured item");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-road traffic light core
// Drives timer steps, scans and reloads through the item channel, writes
// the phase times between phases, and checks every result against a
// cycle-free prediction of lamps, segments, digit enables and timer reload.
// ----------------------------------------------------------------------------
module tb_top;
    import trl_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_TOP   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    localparam int SETTLE_CYCLES = 4;     // pipeline is two deep, leave margin
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int SEGMENT_ITEMS = 205;

    // ------------------------------------------------------------------------
    // Prediction of the visible levels plus the queue of pending results
    // ------------------------------------------------------------------------
    class lamp_display_board;
        logic [CNT_W-1:0] red_t, yellow_t, green_t;
        logic [1:0]       ph1, ph2;
        logic [CNT_W-1:0] cnt1, cnt2;
        logic [5:0]       lamp_q;
        logic [6:0]       seg_q;
        logic [2:0]       scan_q;
        logic [4:0]       en_q;
        logic [6:0]       seg_code [10];
        t_out_item        levels_due [$];
        int               errors;

        function new();
            red_t    = 7'd5;
            yellow_t = 7'd2;
            green_t  = 7'd3;
            ph1      = PH_RED;
            ph2      = PH_GREEN;
            cnt1     = 7'd5;
            cnt2     = 7'd3;
            lamp_q   = 6'h3F;
            seg_q    = 7'h7F;
            scan_q   = 3'd0;
            en_q     = 5'd0;
            errors   = 0;
            seg_code = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                         7'h12, 7'h02, 7'h78, 7'h00, 7'h10};
        endfunction

        function void set_time(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
            case (idx)
                REG_RED_TIME:    red_t    = val;
                REG_YELLOW_TIME: yellow_t = val;
                REG_GREEN_TIME:  green_t  = val;
                default: ;
            endcase
        endfunction

        // active-low lamps of one road, bit 0 red
        function logic [2:0] road_lamps(logic [1:0] ph);
            case (ph)
                PH_YELLOW: return 3'b101;
                PH_GREEN:  return 3'b011;
                default:   return 3'b110;
            endcase
        endfunction

        // count down, on underflow move to next phase; zero time loads zero
        function void step_road(inout logic [1:0] ph, inout logic [CNT_W-1:0] cnt);
            if (cnt != 0) begin
                cnt = cnt - 1'b1;
            end else begin
                case (ph)
                    PH_YELLOW: begin
                        ph  = PH_RED;
                        cnt = (red_t == 0) ? 7'd0 : red_t - 1'b1;
                    end
                    PH_GREEN: begin
                        ph  = PH_YELLOW;
                        cnt = (yellow_t == 0) ? 7'd0 : yellow_t - 1'b1;
                    end
                    default: begin
                        ph  = PH_GREEN;
                        cnt = (green_t == 0) ? 7'd0 : green_t - 1'b1;
                    end
                endcase
            end
        endfunction

        function void predict_levels(t_in_item it);
            t_out_item  lv;
            logic [5:0] mask;
            logic [2:0] pos;
            int         v1, v2, digit;
            lv.reload_ticks = TICKS_NONE;
            case (it.command)
                CMD_STEP: begin
                    if (it.op_mode == MODE_NORMAL) begin
                        step_road(ph1, cnt1);
                        step_road(ph2, cnt2);
                        lamp_q = {road_lamps(ph2), road_lamps(ph1)};
                        lv.reload_ticks = TICKS_NORMAL;
                    end else if (it.op_mode >= MODE_RED && it.op_mode <= MODE_GREEN) begin
                        // blink one colour on both roads, all others dark
                        mask   = 6'b001001 << (it.op_mode - MODE_RED);
                        lamp_q = ((lamp_q ^ mask) & mask) | ~mask;
                        lv.reload_ticks = TICKS_BLINK;
                    end
                end
                CMD_SCAN: begin
                    pos = (scan_q > SCAN_LAST) ? 3'd0 : scan_q;
                    v1  = 0;
                    v2  = 0;
                    if (it.op_mode == MODE_NORMAL) begin
                        v1 = cnt1;
                        v2 = cnt2;
                    end else if (it.op_mode >= MODE_RED && it.op_mode <= MODE_GREEN) begin
                        v1 = it.shown_draft;
                        v2 = it.shown_draft;
                    end
                    en_q = 5'b00001 << pos;
                    case (pos)
                        3'd0:    digit = v1 / 10;
                        3'd1:    digit = v1 % 10;
                        3'd2:    digit = v2 / 10;
                        3'd3:    digit = v2 % 10;
                        default: digit = it.op_mode;
                    endcase
                    // out-of-range digit leaves the segments as they were
                    if (digit <= DIGIT_MAX) seg_q = seg_code[digit];
                    scan_q = (pos == SCAN_LAST) ? 3'd0 : pos + 1'b1;
                end
                CMD_RELOAD: begin
                    cnt1 = red_t;
                    cnt2 = green_t;
                    ph1  = PH_RED;
                    ph2  = PH_GREEN;
                end
                default: ;
            endcase
            lv.lamps         = lamp_q;
            lv.segments      = seg_q;
            lv.digit_enables = en_q;
            levels_due.push_back(lv);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
            errors++;
        endtask

        task check_levels(t_out_item got);
            t_out_item want;
            if (levels_due.size() == 0) begin
                report("result with nothing pending", got, 0);
            end else begin
                want = levels_due.pop_front();
                if (got.lamps !== want.lamps) report("lamps", got.lamps, want.lamps);
                if (got.segments !== want.segments)
                    report("segments", got.segments, want.segments);
                if (got.digit_enables !== want.digit_enables)
                    report("digit_enables", got.digit_enables, want.digit_enables);
                if (got.reload_ticks !== want.reload_ticks)
                    report("reload_ticks", got.reload_ticks, want.reload_ticks);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block hookup
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_item   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out;
    logic                 o_cfg_ready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    lamp_display_board board;

    two_road_traffic_light_with_scan_display_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: outputs are sampled at the edge, before the block's own
    // registers move, so the transfer test sees the pre-edge levels. The
    // stall for the next cycle is drawn at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) board.check_levels(o_out);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: any transfer on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One item transfer. The random gap lowers valid in steps of its own, so
    // valid is never dropped and raised in the same step; payload is held
    // while stalled.
    task automatic send(input logic [1:0] cmd, input logic [2:0] mode,
                        input logic [6:0] draft);
        t_in_item it;
        it.command     = cmd;
        it.op_mode     = mode;
        it.shown_draft = draft;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.predict_levels(it);
    endtask

    // One register write; valid stays up across back-to-back writes and is
    // lowered by the caller after the last transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_time(idx, val);
    endtask

    // Sender holds off until every pending result is back, then lets the block
    // empty its pipeline.
    task automatic wait_all_levels();
        in_valid <= 1'b0;
        while (board.levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random traffic: a mode and its draft persist like a user sitting in
    // one mode, with steps and scans dominating; a few items are pure noise.
    task automatic run_random(input int count);
        logic [1:0] cmd;
        logic [2:0] mode;
        logic [6:0] draft;
        int         pick;
        mode  = MODE_NORMAL;
        draft = 7'd0;
        repeat (count) begin
            if ($urandom_range(99) < 8) begin
                pick = $urandom_range(99);
                if (pick < 60)      mode = MODE_NORMAL;
                else if (pick < 88) mode = 3'($urandom_range(MODE_GREEN, MODE_RED));
                else                mode = 3'($urandom_range(7));
                draft = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                                 : 7'($urandom_range(99));
            end
            pick = $urandom_range(99);
            if (pick < 46)      cmd = CMD_STEP;
            else if (pick < 86) cmd = CMD_SCAN;
            else if (pick < 94) cmd = CMD_RELOAD;
            else                cmd = CMD_UNUSED;
            if ($urandom_range(19) == 0) send(2'($urandom), 3'($urandom), 7'($urandom));
            else                         send(cmd, mode, draft);
        end
    endtask

    // Drain, retime the phases (plus a write to the unused index), then run
    // a stretch of random items under the given idle rates.
    task automatic run_segment(input int spct, input int rpct, input logic [CNT_W-1:0] r,
                               input logic [CNT_W-1:0] y, input logic [CNT_W-1:0] g);
        wait_all_levels();
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        write_reg(REG_RED_TIME, r);
        write_reg(REG_YELLOW_TIME, y);
        write_reg(REG_GREEN_TIME, g);
        write_reg(REG_NONE, 7'($urandom));
        cfg_valid <= 1'b0;
        run_random(SEGMENT_ITEMS);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        board = new();
        send_idle_pct = 28;
        recv_idle_pct = 52;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset times 5/2/3. Full scan of the counts in normal mode.
        repeat (5) send(CMD_SCAN, MODE_NORMAL, 7'd0);
        // draft of 127: tens digit 12 keeps the old segments, units shows 7
        repeat (2) send(CMD_SCAN, MODE_RED, 7'd127);
        // idle mode shows zeros, then the mode digit itself
        repeat (3) send(CMD_SCAN, MODE_TOP, 7'd127);
        // road 2 underflows green->yellow on step 4, road 1 red->green on 6
        repeat (6) send(CMD_STEP, MODE_NORMAL, 7'd99);
        // blink modes, red twice to see the toggle
        send(CMD_STEP, MODE_RED, 7'd0);
        send(CMD_STEP, MODE_RED, 7'd0);
        send(CMD_STEP, MODE_YELLOW, 7'd99);
        send(CMD_STEP, MODE_GREEN, 7'd99);
        // step in an idle mode changes nothing, unused command is ignored
        send(CMD_STEP, MODE_OFF, 7'd0);
        send(CMD_UNUSED, MODE_NORMAL, 7'd0);
        send(CMD_RELOAD, MODE_NORMAL, 7'd0);

        // Random phases: sender/receiver idle 28/52, then 52/28, then none.
        run_segment(28, 52, 7'd1, 7'd1, 7'd1);
        run_segment(28, 52, 7'd0, 7'd127, 7'd0);
        run_segment(52, 28, 7'd99, 7'd99, 7'd99);
        run_segment(52, 28, 7'($urandom_range(12, 1)), 7'($urandom_range(12, 1)),
                    7'($urandom_range(12, 1)));
        run_segment(0, 0, 7'd127, 7'd0, 7'd99);
        run_segment(0, 0, 7'($urandom_range(9)), 7'($urandom_range(9)),
                    7'($urandom_range(9)));

        wait_all_levels();
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
